// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. They expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/avd_pkg.sv =====
`default_nettype none

package avd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = 1023;
  localparam int SCALE_W    = 7;
  localparam int VALUE_W    = 7;
  localparam int DIGIT_W    = 4;
  localparam int SEG_W      = 7;
  localparam int ENABLE_W   = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd33;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = 7'd99;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  localparam logic [ENABLE_W-1:0] ENABLE_UNITS = 2'b01;
  localparam logic [ENABLE_W-1:0] ENABLE_TENS  = 2'b10;

  localparam logic [SEG_W-1:0] SEG_CODES [10] = '{
    7'h77, 7'h41, 7'h3b, 7'h6b, 7'h4d, 7'h6e, 7'h7e, 7'h43, 7'h7f, 7'h4f
  };

  function automatic logic [DIGIT_W-1:0] tens_of(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] t;
    t = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= VALUE_W'(k * 10)) begin
        t = DIGIT_W'(k);
      end
    end
    return t;
  endfunction

  function automatic logic [DIGIT_W-1:0] units_of(input logic [VALUE_W-1:0] v,
                                                  input logic [DIGIT_W-1:0] t);
    logic [VALUE_W-1:0] t10;
    logic [VALUE_W-1:0] u;
    t10 = VALUE_W'({t, 3'b000}) + VALUE_W'({t, 1'b0});
    u   = v - t10;
    return u[DIGIT_W-1:0];
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    return SEG_CODES[d];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/avd_in_if.sv =====
`default_nettype none

interface avd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [avd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/avd_out_if.sv =====
`default_nettype none

interface avd_out_if;
  logic                         valid;
  logic                         ready;
  logic [avd_pkg::ENABLE_W-1:0] digit_enable;
  logic [avd_pkg::SEG_W-1:0]    segments;

  modport source (output valid, output digit_enable, output segments, input ready);
  modport sink   (input valid, input digit_enable, input segments, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adc_average_voltmeter_display.sv =====
// Channel   Dir  Word                          Handshake
// in_ch     in   action, sample                valid/ready
// out_ch    out  digit_enable, segments        valid/ready
// cfg       in   cfg_wdata (scale_r)           cfg_we, no wait
//
// One word per cycle while in_ch.ready is high: every word is finished in the cycle it is accepted.
// A refresh tick loads the output register; a sample only updates the state.
// in_ch.ready drops only while a result waits in the output register and
// out_ch.ready is low. Synchronous reset clears the state and sets scale_r to SCALE_RESET.
`default_nettype none

module adc_average_voltmeter_display #(
  parameter int SAMPLES        = 8,
  parameter int ADC_FULL_SCALE = 1023
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  avd_in_if.sink                           in_ch,
  avd_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [avd_pkg::SCALE_W-1:0] cfg_wdata
);

  import avd_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W = $clog2(SAMPLES * SAMPLE_MAX + 1);
  localparam int PRD_W = SUM_W + SCALE_W;
  localparam longint unsigned DIVISOR = longint'(SAMPLES) * longint'(ADC_FULL_SCALE);
  localparam int DIV_W = $clog2(DIVISOR);
  localparam int SHIFT = PRD_W + DIV_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;
  localparam int RCP_W = PRD_W + 1;
  localparam int MUL_W = PRD_W + RCP_W;

  logic [SCALE_W-1:0]  scale_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PRD_W-1:0]    shown_prd_r, shown_prd_nxt;
  logic                tens_turn_r, tens_turn_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ENABLE_W-1:0] out_enable_r;
  logic [SEG_W-1:0]    out_seg_r;

  logic                in_acc, is_tick, group_done;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W:0]      count_inc;
  logic [MUL_W-1:0]    quot_full;
  logic [VALUE_W-1:0]  shown_value;
  logic [DIGIT_W-1:0]  tens, units;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_tick     = in_ch.action == ACTION_TICK;

  assign sum_add    = sum_r + SUM_W'(in_ch.sample);
  assign count_inc  = {1'b0, count_r} + (CNT_W + 1)'(1);
  assign group_done = count_inc >= (CNT_W + 1)'(SAMPLES);

  assign quot_full   = ((MUL_W)'(shown_prd_r) * (MUL_W)'(RECIP)) >> SHIFT;
  assign shown_value = (quot_full > MUL_W'(VALUE_MAX)) ? VALUE_MAX : quot_full[VALUE_W-1:0];
  assign tens        = tens_of(shown_value);
  assign units       = units_of(shown_value, tens);

  always_comb begin
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    shown_prd_nxt = shown_prd_r;
    tens_turn_nxt = tens_turn_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_acc) begin
      if (is_tick) begin
        tens_turn_nxt = !tens_turn_r;
        out_valid_nxt = 1'b1;
      end else if (group_done) begin
        sum_nxt       = '0;
        count_nxt     = '0;
        shown_prd_nxt = PRD_W'(sum_add) * PRD_W'(scale_r);
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RESET;
      sum_r       <= '0;
      count_r     <= '0;
      shown_prd_r <= '0;
      tens_turn_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      shown_prd_r <= shown_prd_nxt;
      tens_turn_r <= tens_turn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_tick) begin
      out_enable_r <= tens_turn_r ? ENABLE_TENS : ENABLE_UNITS;
      out_seg_r    <= seg_of(tens_turn_r ? tens : units);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digit_enable = out_enable_r;
  assign out_ch.segments     = out_seg_r;

  `ASSERT_NEXT(a_tick_loads_out, in_acc && is_tick, out_valid_r, "tick gave no result")
  `ASSERT_NEXT(a_digit_alternates, in_acc && is_tick,
    out_enable_r == ($past(tens_turn_r) ? ENABLE_TENS : ENABLE_UNITS), "digit order broken")
  `ASSERT_NEXT(a_sample_keeps_turn, in_acc && !is_tick, $stable(tens_turn_r),
    "sample moved the digit turn")
  `ASSERT_SAME(a_count_in_range, 1'b1, {1'b0, count_r} < (CNT_W + 1)'(SAMPLES),
    "sample count overran the group")

endmodule

`default_nettype wire
